// ===== rtl/oair_pkg.sv =====
// Shared types, codes and constants for the ordered array block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package oair_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int RUN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] K_POP    = 3'd2;
    localparam logic [KIND_W-1:0] K_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEAR  = 3'd4;
    localparam logic [KIND_W-1:0] K_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic capture;
        logic execute;
    } oair_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/oair_ctrl.sv =====
// Controller: item capture, execute sequencing and result-valid tracking.
// Depends on oair_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oair_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output oair_pkg::oair_cmd_t cmd
);
    import oair_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free     = !out_valid_reg || result_ready;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.execute)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/oair_datapath.sv =====
// Datapath: item registers, row of shifting cells, count and result registers.
// Depends on oair_pkg; driven by oair_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module oair_datapath #(
    parameter int CAPACITY   = oair_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = oair_pkg::WORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  oair_pkg::oair_cmd_t             cmd,
    input  logic [oair_pkg::KIND_W-1:0]     kind,
    input  logic [oair_pkg::INDEX_W-1:0]    index,
    input  logic [oair_pkg::VALUE_W-1:0]    value,
    input  logic [oair_pkg::RUN_W-1:0]      run_remaining,
    output logic [oair_pkg::STATUS_W-1:0]   status,
    output logic [oair_pkg::COUNT_W-1:0]    count,
    output logic [oair_pkg::VALUE_W-1:0]    read_value
);
    import oair_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

    logic [KIND_W-1:0]     kind_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [RUN_W-1:0]      run_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  reject_reg;
    logic                  reject_next;

    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [COUNT_W-1:0]    count_out_reg;
    logic [VALUE_W-1:0]    read_reg;
    logic [VALUE_W-1:0]    read_next;

    logic [WORD_WIDTH-1:0] cell_reg [CAPACITY];

    logic [CMP_W-1:0]      count_w;
    logic [CMP_W-1:0]      idx_w;
    logic [CMP_W-1:0]      run_w;
    logic [CMP_W-1:0]      cap_w;
    logic [ADDR_W-1:0]     idx_sel;
    logic                  do_append;
    logic                  do_insert;
    logic                  do_remove;

    assign count_w = CMP_W'(count_reg);
    assign idx_w   = CMP_W'(index_reg);
    assign run_w   = (run_reg == '0) ? CMP_W'(1) : CMP_W'(run_reg);
    assign cap_w   = CMP_W'(CAPACITY);
    assign idx_sel = ADDR_W'(index_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            index_reg <= index;
            word_reg  <= WORD_WIDTH'(value);
            run_reg   <= run_remaining;
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        read_next   = '0;
        count_next  = count_reg;
        reject_next = reject_reg;
        do_append   = 1'b0;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        if (kind_reg == K_INSERT || kind_reg == K_POP || kind_reg == K_REMOVE ||
            kind_reg == K_CLEAR || kind_reg == K_READ)
            reject_next = 1'b0;
        unique case (kind_reg)
            K_APPEND:
            begin
                priority if (reject_reg)
                begin
                    status_next = ST_FULL;
                    if (run_w <= CMP_W'(1))
                        reject_next = 1'b0;
                end
                else if (count_w + run_w > cap_w)
                begin
                    status_next = ST_FULL;
                    if (run_w > CMP_W'(1))
                        reject_next = 1'b1;
                end
                else
                begin
                    do_append  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            K_INSERT:
            begin
                priority if (idx_w > count_w)
                    status_next = ST_RANGE;
                else if (count_w >= cap_w)
                    status_next = ST_FULL;
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            K_POP:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            K_REMOVE:
            begin
                if (idx_w >= count_w)
                    status_next = ST_RANGE;
                else
                begin
                    do_remove  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            K_CLEAR:
            begin
                count_next = '0;
            end
            K_READ:
            begin
                if (idx_w >= count_w)
                    status_next = ST_RANGE;
                else
                    read_next = VALUE_W'(cell_reg[idx_sel]);
            end
            default:
            begin
                reject_next = reject_reg;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] POS = CMP_W'(i);
        logic [WORD_WIDTH-1:0] cell_next;
        logic [WORD_WIDTH-1:0] left_word;
        logic [WORD_WIDTH-1:0] right_word;

        if (i > 0)
        begin : g_left
            assign left_word = cell_reg[i-1];
        end
        else
        begin : g_no_left
            assign left_word = word_reg;
        end

        if (i < CAPACITY - 1)
        begin : g_right
            assign right_word = cell_reg[i+1];
        end
        else
        begin : g_no_right
            assign right_word = cell_reg[i];
        end

        always_comb
        begin
            cell_next = cell_reg[i];
            priority if (do_append && POS == count_w)
                cell_next = word_reg;
            else if (do_insert && POS == idx_w)
                cell_next = word_reg;
            else if (do_insert && POS > idx_w)
                cell_next = left_word;
            else if (do_remove && POS >= idx_w)
                cell_next = right_word;
            else
                cell_next = cell_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.execute)
                cell_reg[i] <= cell_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            reject_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            count_reg  <= count_next;
            reject_reg <= reject_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= status_next;
            count_out_reg <= COUNT_W'(count_next);
            read_reg      <= read_next;
        end
    end

    assign status     = status_reg;
    assign count      = count_out_reg;
    assign read_value = read_reg;

endmodule

`default_nettype wire

// ===== rtl/ordered_array_insert_remove.sv =====
// Top level of the ordered array: controller plus datapath.
// Depends on oair_pkg, oair_ctrl and oair_datapath.
//
// Ordered word array with append, insert, pop, remove, clear and read. Each
// transaction has a capture step for the item and an execute step in which
// the row of cells shifts, writes or is read and the result register loads.
// The result register lets the next item be taken while a result waits; the
// execute step holds off until that register is free, so a stalled result
// side sets the pace. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_insert_remove #(
    parameter int CAPACITY   = oair_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = oair_pkg::WORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [oair_pkg::KIND_W-1:0]     kind,
    input  logic [oair_pkg::INDEX_W-1:0]    index,
    input  logic [oair_pkg::VALUE_W-1:0]    value,
    input  logic [oair_pkg::RUN_W-1:0]      run_remaining,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [oair_pkg::STATUS_W-1:0]   status,
    output logic [oair_pkg::COUNT_W-1:0]    count,
    output logic [oair_pkg::VALUE_W-1:0]    read_value
);
    import oair_pkg::*;

    oair_cmd_t cmd;

    oair_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    oair_datapath #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .index         (index),
        .value         (value),
        .run_remaining (run_remaining),
        .status        (status),
        .count         (count),
        .read_value    (read_value)
    );

endmodule

`default_nettype wire

// ===== rtl/oair_checker.sv =====
// Port-level checks for the ordered array, with the bind to its top level.
// Depends on oair_pkg and ordered_array_insert_remove.
`timescale 1ns / 1ps
`default_nettype none

module oair_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [oair_pkg::STATUS_W-1:0]   status,
    input logic [oair_pkg::COUNT_W-1:0]    count,
    input logic [oair_pkg::VALUE_W-1:0]    read_value
);
    import oair_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(status) && $stable(count) && $stable(read_value))
        else $error("result changed while stalled");

    a_read_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |-> read_value == '0)
        else $error("read_value nonzero on error status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_EMPTY |-> count == '0)
        else $error("empty status with nonzero count");

endmodule

bind ordered_array_insert_remove oair_checker u_oair_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .count        (count),
    .read_value   (read_value)
);

`default_nettype wire
